@@ rtl/qslp_pkg.sv @@
// ----------------------------------------------------------------------------
// qslp_pkg
// Shared constants for the quaternion slerp pipeline: fixed-point format,
// CORDIC arctangent table and the stage counts of the iterative units.
// ----------------------------------------------------------------------------
`default_nettype none

package qslp_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int ONE          = 1 << FRAC_BITS;
  localparam int CORDIC_ITERS = 30;
  localparam int SQRT_STAGES  = 31;
  localparam int DIV_STAGES   = 31;

  localparam logic [31:0] CORDIC_K = 32'h26DD3B6A;

  // atan(2^-i) in Q30 radians, truncated
  localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
  };

endpackage

`default_nettype wire

@@ rtl/quaternion_slerp.sv @@
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point quaternion slerp: dot product, sqrt, CORDIC half angle,
// CORDIC sines, reciprocal weights and a saturated blend, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  input    | in_valid / in_stall  | a_w a_x a_y a_z b_w b_x b_y b_z blend
//  output   | out_valid / out_stall| out_w out_x out_y out_z
//  config   | cfg_wen              | cfg_wdata (near_epsilon)
//
//  one beat enters per cycle unless stalled; the depth comes from the square root
//  (31 stages), the two CORDIC passes (30 each) and the divider (31 stages)
//  rst clears all valid bits and sets near_epsilon to 2
//  a stalled output beat freezes the whole pipeline; in_stall follows it
//
`default_nettype none

module quaternion_slerp (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] a_w,
  input  logic signed [15:0] a_x,
  input  logic signed [15:0] a_y,
  input  logic signed [15:0] a_z,
  input  logic signed [15:0] b_w,
  input  logic signed [15:0] b_x,
  input  logic signed [15:0] b_y,
  input  logic signed [15:0] b_z,
  input  logic        [14:0] blend,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_w,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  input  logic               cfg_wen,
  input  logic        [14:0] cfg_wdata
);

  localparam int FB     = qslp_pkg::FRAC_BITS;
  localparam int T_SQRT = qslp_pkg::SQRT_STAGES;
  localparam int T_ATAN = T_SQRT + qslp_pkg::CORDIC_ITERS;
  localparam int T_MUL  = T_ATAN + 1;
  localparam int T_SIN  = T_MUL + qslp_pkg::CORDIC_ITERS;
  localparam int T_DIV  = T_SIN + qslp_pkg::DIV_STAGES;
  localparam int S30_D  = T_SIN - T_SQRT;
  localparam int VDEPTH = T_DIV + 5;

  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][15:0] b;
    logic [14:0]      t;
    logic             neg;
    logic             slerp;
    logic [29:0]      c30;
  } side_t;

  logic              en;
  logic [14:0]       near_epsilon;
  logic [VDEPTH-1:0] vpipe;

  assign en       = !(vpipe[VDEPTH-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vpipe[VDEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      near_epsilon <= 15'd2;
    end else if (cfg_wen) begin
      near_epsilon <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[VDEPTH-2:0], in_valid};
    end
  end

  // stage 1: component products, t saturated to one
  logic signed [15:0] in_a [4];
  logic signed [15:0] in_b [4];
  logic [3:0][15:0]   f1_a;
  logic [3:0][15:0]   f1_b;
  logic signed [31:0] f1_prod [4];
  logic [14:0]        f1_t;

  assign in_a = '{a_w, a_x, a_y, a_z};
  assign in_b = '{b_w, b_x, b_y, b_z};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        f1_a[k]    <= in_a[k];
        f1_b[k]    <= in_b[k];
        f1_prod[k] <= 32'(in_a[k]) * 32'(in_b[k]);
      end
      f1_t <= (blend > 15'(qslp_pkg::ONE)) ? 15'(qslp_pkg::ONE) : blend;
    end
  end

  // stage 2: dot product, magnitude and slerp decision
  logic signed [33:0] dot;
  logic        [32:0] absdot;
  logic signed [16:0] thr;
  logic        [32:0] thr_sh;
  logic               use_slerp;
  side_t              f2_side;

  assign dot = 34'(f1_prod[0]) + 34'(f1_prod[1]) + 34'(f1_prod[2]) + 34'(f1_prod[3]);
  assign absdot = (dot < 0) ? 33'(-dot) : 33'(dot);
  assign thr = 17'(qslp_pkg::ONE) - $signed({2'b00, near_epsilon});
  assign thr_sh = 33'(thr[15:0]) << FB;
  assign use_slerp = (thr > 0) && (absdot < thr_sh);

  always_ff @(posedge clk) begin
    if (en) begin
      f2_side.a     <= f1_a;
      f2_side.b     <= f1_b;
      f2_side.t     <= f1_t;
      f2_side.neg   <= (dot < 0);
      f2_side.slerp <= use_slerp;
      // cosine in Q30; zero off the slerp path keeps the sqrt input in range
      f2_side.c30   <= use_slerp ? 30'(absdot << (30 - 2 * FB)) : '0;
    end
  end

  // stage 3: cosine squared; side data line starts here
  logic [59:0] csq;
  side_t       sline [0:T_DIV];
  logic [30:0] s30d  [0:S30_D-1];

  always_ff @(posedge clk) begin
    if (en) begin
      csq      <= f2_side.c30 * f2_side.c30;
      sline[0] <= f2_side;
      for (int i = 1; i <= T_DIV; i++) begin
        sline[i] <= sline[i-1];
      end
    end
  end

  // sine of the half angle
  logic [60:0] sq_in;
  logic [30:0] s30;

  assign sq_in = (61'(1) << 60) - 61'(csq);

  qslp_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .v_in (sq_in),
    .root (s30)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s30d[0] <= s30;
      for (int i = 1; i < S30_D; i++) begin
        s30d[i] <= s30d[i-1];
      end
    end
  end

  // half angle h = atan2(sin h, cos h)
  logic signed [32:0] z_atan;
  logic        [30:0] h;

  qslp_cordic u_atan (
    .clk       (clk),
    .en        (en),
    .vectoring (1'b1),
    .x_in      ($signed({4'b0000, sline[T_SQRT].c30})),
    .y_in      ($signed({3'b000, s30})),
    .z_in      (33'sd0),
    .x_out     (),
    .y_out     (),
    .z_out     (z_atan)
  );

  assign h = (z_atan < 0) ? '0 : z_atan[30:0];

  // angles h(1-t) and h*t
  logic [14:0] omt;
  logic [45:0] pa_full;
  logic [45:0] pb_full;
  logic [30:0] pa;
  logic [30:0] pb;

  assign omt     = 15'(qslp_pkg::ONE) - sline[T_ATAN].t;
  assign pa_full = 46'(h) * 46'(omt);
  assign pb_full = 46'(h) * 46'(sline[T_ATAN].t);

  always_ff @(posedge clk) begin
    if (en) begin
      pa <= pa_full[FB+30:FB];
      pb <= pb_full[FB+30:FB];
    end
  end

  logic signed [33:0] y_sin_a;
  logic signed [33:0] y_sin_b;
  logic        [31:0] sin_a;
  logic        [31:0] sin_b;

  qslp_cordic u_sin_a (
    .clk       (clk),
    .en        (en),
    .vectoring (1'b0),
    .x_in      ($signed({2'b00, qslp_pkg::CORDIC_K})),
    .y_in      (34'sd0),
    .z_in      ($signed({2'b00, pa})),
    .x_out     (),
    .y_out     (y_sin_a),
    .z_out     ()
  );

  qslp_cordic u_sin_b (
    .clk       (clk),
    .en        (en),
    .vectoring (1'b0),
    .x_in      ($signed({2'b00, qslp_pkg::CORDIC_K})),
    .y_in      (34'sd0),
    .z_in      ($signed({2'b00, pb})),
    .x_out     (),
    .y_out     (y_sin_b),
    .z_out     ()
  );

  assign sin_a = (y_sin_a < 0) ? '0 : y_sin_a[31:0];
  assign sin_b = (y_sin_b < 0) ? '0 : y_sin_b[31:0];

  logic [30:0] q_a;
  logic [30:0] q_b;

  qslp_div u_div_a (
    .clk  (clk),
    .en   (en),
    .num  (sin_a),
    .den  (s30d[S30_D-1]),
    .quot (q_a)
  );

  qslp_div u_div_b (
    .clk  (clk),
    .en   (en),
    .num  (sin_b),
    .den  (s30d[S30_D-1]),
    .quot (q_b)
  );

  // weights and weighted components
  side_t              ws;
  logic signed [32:0] wa;
  logic signed [32:0] wb_mag;
  logic signed [32:0] wb;
  logic signed [48:0] wp_a [4];
  logic signed [48:0] wp_b [4];

  assign ws     = sline[T_DIV];
  assign wa     = ws.slerp ? $signed({2'b00, q_a})
                           : $signed(33'(15'(qslp_pkg::ONE) - ws.t));
  assign wb_mag = ws.slerp ? $signed({2'b00, q_b}) : $signed(33'(ws.t));
  // shorter path: flip the second weight on a negative dot product
  assign wb     = ws.neg ? -wb_mag : wb_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        wp_a[k] <= 49'($signed(ws.a[k])) * 49'(wa);
        wp_b[k] <= 49'($signed(ws.b[k])) * 49'(wb);
      end
    end
  end

  // round half up, saturate
  logic signed [49:0] sum   [4];
  logic signed [35:0] shv   [4];
  logic signed [15:0] satv  [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = 50'(wp_a[k]) + 50'(wp_b[k]) + 50'(1 << (FB - 1));
      shv[k] = 36'(sum[k] >>> FB);
      if (shv[k] > 36'sd32767) begin
        satv[k] = 16'sh7FFF;
      end else if (shv[k] < -36'sd32768) begin
        satv[k] = 16'sh8000;
      end else begin
        satv[k] = shv[k][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_w <= satv[0];
      out_x <= satv[1];
      out_y <= satv[2];
      out_z <= satv[3];
    end
  end

  // the divisor is never zero where the slerp weights are taken
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    vpipe[T_SIN+2] && sline[T_SIN].slerp |-> s30d[S30_D-1] != '0)
    else $error("zero divisor on slerp path");

  // a frozen pipeline keeps its valid bits
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vpipe))
    else $error("valid bits moved during stall");

  // an accepted beat shows up in the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vpipe[0])
    else $error("accepted beat lost at entry");

  // slerp is never chosen when the cosine reaches one: 1 - c^2 stays positive
  a_slerp_cos: assert property (@(posedge clk) disable iff (rst)
    vpipe[2] && sline[0].slerp |-> sq_in >= 61'h7FFF_FFFF)
    else $error("cosine out of range on slerp path");

endmodule

`default_nettype wire

@@ rtl/qslp_sqrt.sv @@
// ----------------------------------------------------------------------------
// qslp_sqrt
// Pipelined floor square root of a 61-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qslp_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] v_in,
  output logic [30:0] root
);

  localparam int N = qslp_pkg::SQRT_STAGES;

  logic [60:0] vr [1:N];
  logic [60:0] rr [1:N];
  logic [60:0] vs [0:N-1];
  logic [60:0] rs [0:N-1];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam logic [60:0] BITV = 61'(1) << (2 * (N - 1 - j));
    logic [60:0] trial;

    if (j == 0) begin : g_first
      assign vs[j] = v_in;
      assign rs[j] = '0;
    end else begin : g_rest
      assign vs[j] = vr[j];
      assign rs[j] = rr[j];
    end

    assign trial = rs[j] + BITV;

    always_ff @(posedge clk) begin
      if (en) begin
        if (vs[j] >= trial) begin
          vr[j+1] <= vs[j] - trial;
          rr[j+1] <= (rs[j] >> 1) + BITV;
        end else begin
          vr[j+1] <= vs[j];
          rr[j+1] <= rs[j] >> 1;
        end
      end
    end
  end

  assign root = rr[N][30:0];

endmodule

`default_nettype wire

@@ rtl/qslp_cordic.sv @@
// ----------------------------------------------------------------------------
// qslp_cordic
// Unrolled CORDIC, one micro-rotation per stage, vectoring or rotation mode.
// ----------------------------------------------------------------------------
`default_nettype none

module qslp_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic               vectoring,
  input  logic signed [33:0] x_in,
  input  logic signed [33:0] y_in,
  input  logic signed [32:0] z_in,
  output logic signed [33:0] x_out,
  output logic signed [33:0] y_out,
  output logic signed [32:0] z_out
);

  localparam int N = qslp_pkg::CORDIC_ITERS;

  logic signed [33:0] xr [1:N];
  logic signed [33:0] yr [1:N];
  logic signed [32:0] zr [1:N];
  logic signed [33:0] xs [0:N-1];
  logic signed [33:0] ys [0:N-1];
  logic signed [32:0] zs [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic               ccw;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [32:0] da;

    if (k == 0) begin : g_first
      assign xs[k] = x_in;
      assign ys[k] = y_in;
      assign zs[k] = z_in;
    end else begin : g_rest
      assign xs[k] = xr[k];
      assign ys[k] = yr[k];
      assign zs[k] = zr[k];
    end

    assign dx  = ys[k] >>> k;
    assign dy  = xs[k] >>> k;
    assign da  = $signed({1'b0, qslp_pkg::ATAN_TAB[k]});
    // vectoring drives y toward zero, rotation drives z toward zero
    assign ccw = vectoring ? (ys[k] <= 0) : (zs[k] >= 0);

    always_ff @(posedge clk) begin
      if (en) begin
        if (ccw) begin
          xr[k+1] <= xs[k] - dx;
          yr[k+1] <= ys[k] + dy;
          zr[k+1] <= zs[k] - da;
        end else begin
          xr[k+1] <= xs[k] + dx;
          yr[k+1] <= ys[k] - dy;
          zr[k+1] <= zs[k] + da;
        end
      end
    end
  end

  assign x_out = xr[N];
  assign y_out = yr[N];
  assign z_out = zr[N];

endmodule

`default_nettype wire

@@ rtl/qslp_div.sv @@
// ----------------------------------------------------------------------------
// qslp_div
// Pipelined restoring divider: round(num * ONE / den), one quotient bit per
// stage. The quotient is known to stay below 2^31 on the slerp path.
// ----------------------------------------------------------------------------
`default_nettype none

module qslp_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [30:0] den,
  output logic [30:0] quot
);

  localparam int N  = qslp_pkg::DIV_STAGES;
  localparam int NW = 32 + qslp_pkg::FRAC_BITS + 1;

  logic [NW-1:0] nfull;

  logic [31:0] remr [1:N];
  logic [30:0] lowr [1:N];
  logic [30:0] denr [1:N];
  logic [30:0] qr   [1:N];
  logic [31:0] rems [0:N-1];
  logic [30:0] lows [0:N-1];
  logic [30:0] dens [0:N-1];
  logic [30:0] qs   [0:N-1];

  // numerator scaled to the output format plus half the divisor for rounding
  assign nfull = (NW'(num) << qslp_pkg::FRAC_BITS) + NW'(den >> 1);

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int K = N - 1 - j;
    logic [31:0] trial;

    if (j == 0) begin : g_first
      assign rems[j] = 32'(nfull[NW-1:N]);
      assign lows[j] = nfull[N-1:0];
      assign dens[j] = den;
      assign qs[j]   = '0;
    end else begin : g_rest
      assign rems[j] = remr[j];
      assign lows[j] = lowr[j];
      assign dens[j] = denr[j];
      assign qs[j]   = qr[j];
    end

    assign trial = {rems[j][30:0], lows[j][K]};

    always_ff @(posedge clk) begin
      if (en) begin
        lowr[j+1] <= lows[j];
        denr[j+1] <= dens[j];
        if (trial >= {1'b0, dens[j]}) begin
          remr[j+1]  <= trial - {1'b0, dens[j]};
          qr[j+1]    <= qs[j] | (31'(1) << K);
        end else begin
          remr[j+1]  <= trial;
          qr[j+1]    <= qs[j];
        end
      end
    end
  end

  assign quot = qr[N];

endmodule

`default_nettype wire

@@ tb/sv/tb_quaternion_slerp.sv @@
// ----------------------------------------------------------------------------
// tb_quaternion_slerp
// Self-checking bench for the quaternion slerp pipeline. A scoreboard class
// predicts every beat (dot product, sqrt, CORDIC angle and sines, weights,
// rounded and saturated blend) and checks outputs in order under random
// input gaps, output stalls, one long hold-off and several epsilon settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quaternion_slerp;

  localparam int LATENCY    = 128;
  localparam int WATCH_LIMIT = 20000;
  localparam int RAND_ITEMS = 1500;

  typedef struct {
    logic signed [15:0] a [4];
    logic signed [15:0] b [4];
    logic [14:0] t;
  } quat_pair_t;

  typedef struct {
    logic signed [15:0] q [4];
  } quat_t;

  int errors = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic longint half_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < qslp_pkg::CORDIC_ITERS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(qslp_pkg::ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(qslp_pkg::ATAN_TAB[i]);
      end
    end
    return z < 0 ? 0 : z;
  endfunction

  function automatic longint sine_q30(longint z);
    longint x, y, dx, dy;
    x = longint'(qslp_pkg::CORDIC_K);
    y = 0;
    for (int i = 0; i < qslp_pkg::CORDIC_ITERS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(qslp_pkg::ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(qslp_pkg::ATAN_TAB[i]);
      end
    end
    return y < 0 ? 0 : y;
  endfunction

  class slerp_scoreboard;
    logic [14:0] epsilon;
    quat_t pending[$];
    int checked;

    function void reset_state();
      epsilon = 15'd2;
    endfunction

    function void note_input(quat_pair_t p);
      longint one, dot, t, wa, wb, thr, h, pa, pb, v;
      longint unsigned absdot, c30, s30;
      quat_t r;
      one = qslp_pkg::ONE;
      dot = 0;
      for (int k = 0; k < 4; k++) dot += longint'(p.a[k]) * longint'(p.b[k]);
      t = p.t;
      if (t > one) t = one;
      absdot = dot < 0 ? -dot : dot;
      wa = one - t;
      wb = t;
      thr = one - longint'(epsilon);
      if (thr > 0 && absdot < (longint'(thr) << qslp_pkg::FRAC_BITS)) begin
        c30 = absdot << (30 - 2 * qslp_pkg::FRAC_BITS);
        s30 = floor_sqrt((64'd1 << 60) - c30 * c30);
        if (s30 != 0) begin
          h = half_angle(c30, s30);
          pa = (h * (one - t)) >>> qslp_pkg::FRAC_BITS;
          pb = (h * t) >>> qslp_pkg::FRAC_BITS;
          wa = (sine_q30(pa) * one + longint'(s30) / 2) / longint'(s30);
          wb = (sine_q30(pb) * one + longint'(s30) / 2) / longint'(s30);
        end
      end
      if (dot < 0) wb = -wb;
      for (int k = 0; k < 4; k++) begin
        v = longint'(p.a[k]) * wa + longint'(p.b[k]) * wb;
        v = (v + (longint'(1) << (qslp_pkg::FRAC_BITS - 1))) >>> qslp_pkg::FRAC_BITS;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        r.q[k] = v[15:0];
      end
      pending.push_back(r);
    endfunction

    task check_result(quat_t got);
      quat_t want;
      string names [4] = '{"w", "x", "y", "z"};
      if (pending.size() == 0) begin
        report("output beat with nothing expected");
        return;
      end
      want = pending.pop_front();
      checked++;
      for (int k = 0; k < 4; k++)
        if (got.q[k] !== want.q[k])
          report($sformatf("beat %0d out_%s got %0d want %0d",
                           checked, names[k], got.q[k], want.q[k]));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] a_w = 0, a_x = 0, a_y = 0, a_z = 0;
  logic signed [15:0] b_w = 0, b_x = 0, b_y = 0, b_z = 0;
  logic [14:0] blend = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] out_w, out_x, out_y, out_z;
  logic cfg_wen = 0;
  logic [14:0] cfg_wdata = 0;

  quaternion_slerp u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .blend(blend),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  slerp_scoreboard sb = new();
  bit long_hold = 0;
  bit driving_done = 0;
  int sent = 0;

  // valid stays up between back-to-back beats; it drops only for a gap
  task automatic send_pair(input quat_pair_t p);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    a_w <= p.a[0]; a_x <= p.a[1]; a_y <= p.a[2]; a_z <= p.a[3];
    b_w <= p.b[0]; b_x <= p.b[1]; b_y <= p.b[2]; b_z <= p.b[3];
    blend <= p.t;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_input(p);
    sent++;
  endtask

  task automatic write_epsilon(input logic [14:0] value);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    cfg_wdata <= value;
    cfg_wen <= 1;
    @(posedge clk);
    cfg_wen <= 0;
    sb.epsilon = value;
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(int'($urandom_range(0, 65535)));
      default: return 16'(int'($urandom_range(0, 16384)) - 8192);
    endcase
  endfunction

  // mostly near neighbors and near opposites of a random quaternion so slerp paths dominate
  function automatic quat_pair_t rand_pair();
    quat_pair_t p;
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 4; k++) p.a[k] = rand_comp();
    if (kind < 4) begin
      for (int k = 0; k < 4; k++) p.a[k] = 16'($signed(16'(p.a[k])) >>> 2);
      for (int k = 0; k < 4; k++) p.b[k] = 16'(int'(p.a[k]) + int'($urandom_range(0, 64)) - 32);
    end else if (kind < 6) begin
      for (int k = 0; k < 4; k++) p.a[k] = 16'($signed(16'(p.a[k])) >>> 2);
      for (int k = 0; k < 4; k++) p.b[k] = -p.a[k] + 16'(int'($urandom_range(0, 16)) - 8);
    end else begin
      for (int k = 0; k < 4; k++) p.b[k] = rand_comp();
    end
    case ($urandom_range(0, 4))
      0: p.t = 15'(16384 + $urandom_range(0, 16383));
      1: p.t = $urandom_range(0, 1) ? 15'd0 : 15'd16384;
      default: p.t = 15'($urandom_range(0, 16384));
    endcase
    return p;
  endfunction

  function automatic quat_pair_t make_pair(int aw, int ax, int ay, int az,
                                           int bw, int bx, int by, int bz, int t);
    quat_pair_t p;
    p.a = '{16'(aw), 16'(ax), 16'(ay), 16'(az)};
    p.b = '{16'(bw), 16'(bx), 16'(by), 16'(bz)};
    p.t = 15'(t);
    return p;
  endfunction

  task automatic directed_beats();
    send_pair(make_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 8192));
    send_pair(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 8192));
    send_pair(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 0));
    send_pair(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 16384));
    send_pair(make_pair(16384, 0, 0, 0, 11585, 11585, 0, 0, 32767));
    send_pair(make_pair(16384, 0, 0, 0, -11585, 0, 11585, 0, 4096));
    send_pair(make_pair(11585, 11585, 0, 0, -11585, -11585, 0, 0, 8192));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 8192));
    send_pair(make_pair(0, 0, 0, 16384, 16384, 0, 0, 0, 12000));
    send_pair(make_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 16384));
    send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 5000));
    send_pair(make_pair(-32768, 0, 0, 0, -32768, 0, 0, 0, 0));
    send_pair(make_pair(16384, 0, 0, 0, 16383, 181, 0, 0, 8192));
    send_pair(make_pair(8192, 8192, 8192, 8192, 8192, 8192, 8192, -8192, 20000));
    send_pair(make_pair(1, -1, 2, -2, 3, -3, 4, -4, 8192));
  endtask

  initial begin
    sb.reset_state();
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed_beats();
    write_epsilon(15'd0);
    directed_beats();
    write_epsilon(15'd16384);
    directed_beats();
    write_epsilon(15'd32767);
    for (int i = 0; i < 20; i++) send_pair(rand_pair());
    write_epsilon(15'd100);
    long_hold = 1;
    for (int i = 0; i < RAND_ITEMS / 2; i++) send_pair(rand_pair());
    write_epsilon(15'd2);
    for (int i = 0; i < RAND_ITEMS / 2; i++) send_pair(rand_pair());
    write_epsilon(15'(1 + $urandom_range(0, 2000)));
    for (int i = 0; i < 100; i++) send_pair(rand_pair());
    in_valid <= 0;
    driving_done = 1;
  end

  // output stall: random per beat, plus one long hold-off to fill the pipe
  initial begin
    int hold;
    bit held;
    held = 0;
    forever begin
      @(posedge clk);
      if (long_hold && !held) begin
        held = 1;
        out_stall <= 1;
        repeat (400) @(posedge clk);
        out_stall <= 0;
      end else if (out_valid && !out_stall) begin
        hold = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) hold = 0;
        if (hold != 0) begin
          out_stall <= 1;
          repeat (hold) @(posedge clk);
          out_stall <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    quat_t got;
    if (!rst && out_valid && !out_stall) begin
      got.q = '{out_w, out_x, out_y, out_z};
      sb.check_result(got);
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
      if (driving_done && sb.pending.size() == 0) begin
        repeat (LATENCY + 20) @(posedge clk);
        $display("covered %0d beats, %0d outputs checked over six epsilon settings",
                 sent, sb.checked);
        if (errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
      end
      if (idle >= WATCH_LIMIT) begin
        $display("watchdog: no progress, %0d beats still expected", sb.pending.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

@@ quaternion_slerp.f @@
rtl/qslp_pkg.sv
rtl/qslp_sqrt.sv
rtl/qslp_cordic.sv
rtl/qslp_div.sv
rtl/quaternion_slerp.sv
tb/sv/tb_quaternion_slerp.sv
